[hdl/bts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Types, token codes and the keyword table of the B token scanner.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int MAX_TEXT_CHARS = 64;
    localparam int NAME_CHARS     = 8;
    localparam int CNT_W          = $clog2(MAX_TEXT_CHARS + 1);
    localparam int NUM_KW         = 10;
    localparam int MAX_RES        = 3;

    localparam logic [63:0] SPACES = 64'h2020202020202020;

    localparam logic signed [9:0] TK_IDENT   = 10'sd256;
    localparam logic signed [9:0] TK_INT     = 10'sd257;
    localparam logic signed [9:0] TK_STRING  = 10'sd258;
    localparam logic signed [9:0] TK_KW_BASE = 10'sd260;
    localparam logic signed [9:0] TK_LE      = 10'sd270;
    localparam logic signed [9:0] TK_SHL     = 10'sd271;
    localparam logic signed [9:0] TK_GE      = 10'sd272;
    localparam logic signed [9:0] TK_SHR     = 10'sd273;
    localparam logic signed [9:0] TK_NE      = 10'sd274;
    localparam logic signed [9:0] TK_EQEQ    = 10'sd275;
    localparam logic signed [9:0] TK_EQPLUS  = 10'sd276;
    localparam logic signed [9:0] TK_EQMINUS = 10'sd277;
    localparam logic signed [9:0] TK_EQMUL   = 10'sd278;
    localparam logic signed [9:0] TK_EQDIV   = 10'sd279;
    localparam logic signed [9:0] TK_EQMOD   = 10'sd280;
    localparam logic signed [9:0] TK_EQSHL   = 10'sd281;
    localparam logic signed [9:0] TK_EQSHR   = 10'sd282;
    localparam logic signed [9:0] TK_EQAND   = 10'sd283;
    localparam logic signed [9:0] TK_EQOR    = 10'sd284;
    localparam logic signed [9:0] TK_INC     = 10'sd286;
    localparam logic signed [9:0] TK_DEC     = 10'sd287;
    localparam logic signed [9:0] TK_EOF     = -10'sd1;

    localparam logic [7:0] CH_EOT = 8'h04;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_SLASH, M_COMMENT, M_CSTAR, M_STRING,
        M_LT, M_GT, M_BANG, M_EQ, M_EQLT, M_EQGT, M_PLUS, M_MINUS, M_DONE
    } mode_t;

    localparam logic [63:0] KW_NAME [NUM_KW] = '{
        64'h6175746F20202020, 64'h6361736520202020, 64'h64656661756C7420,
        64'h656C736520202020, 64'h657874726E202020, 64'h676F746F20202020,
        64'h6966202020202020, 64'h72657475726E2020, 64'h7377697463682020,
        64'h7768696C65202020
    };

    typedef struct packed {
        logic signed [9:0] token_code;
        logic [15:0]       int_value;
        logic [63:0]       name_text;
        logic [6:0]        text_length;
        logic [15:0]       line_number;
        logic              last;
    } res_t;

endpackage

[hdl/bts_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_in_if
// Source byte channel of the B token scanner.
// ----------------------------------------------------------------------------
interface bts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] input_byte;
    logic       end_of_input;

    modport source (output valid, input ready, output input_byte, output end_of_input);
    modport sink   (input valid, output ready, input input_byte, input end_of_input);
endinterface

[hdl/bts_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_out_if
// Token result channel of the B token scanner.
// ----------------------------------------------------------------------------
interface bts_out_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] token_code;
    logic [15:0]       int_value;
    logic [63:0]       name_text;
    logic [6:0]        text_length;
    logic [15:0]       line_number;
    logic              last;

    modport source (output valid, input ready, output token_code, output int_value,
                    output name_text, output text_length, output line_number,
                    output last);
    modport sink   (input valid, output ready, input token_code, input int_value,
                    input name_text, input text_length, input line_number,
                    input last);
endinterface

[hdl/b_language_token_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b_language_token_scanner
// Scans one source byte per request and emits zero to three tokens.
// ----------------------------------------------------------------------------
// Latency: a byte's first token is valid the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one token and
// the output is ready; a byte with more tokens holds the input while the result
// buffer drains one token per cycle when the output is ready.
// Reset: rst_n clears the scan state to idle, line counter to one, buffer empty.
module b_language_token_scanner
    import bts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bts_in_if.sink     in_chan,
    bts_out_if.source  out_chan
);

    mode_t             mode_reg, mode_next;
    logic [63:0]       name_reg, name_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [15:0]       acc_reg,  acc_next;
    logic              oct_reg,  oct_next;
    logic [15:0]       line_reg, line_next;
    logic              esc_reg,  esc_next;

    res_t              buf_reg [MAX_RES];
    logic [1:0]        qcnt_reg, qcnt_next;
    logic [1:0]        rdp_reg,  rdp_next;

    res_t              res [MAX_RES];
    logic [1:0]        nres;

    logic [7:0]        c;
    logic              eoi;
    logic              accept;
    logic              drain;

    assign c   = in_chan.input_byte;
    assign eoi = in_chan.end_of_input;

    function automatic res_t mk_plain(logic signed [9:0] code, logic [15:0] ln);
        res_t r;
        r.token_code  = code;
        r.int_value   = '0;
        r.name_text   = SPACES;
        r.text_length = '0;
        r.line_number = ln;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic logic signed [9:0] ch_code(logic [7:0] ch);
        return signed'({2'b00, ch});
    endfunction

    function automatic logic [63:0] put_char(logic [63:0] nm, logic [CNT_W-1:0] n,
                                             logic [7:0] ch);
        logic [5:0] sh;
        sh = {~n[2:0], 3'b000};
        if (n < CNT_W'(NAME_CHARS))
            return (nm & ~(64'hFF << sh)) | (64'(ch) << sh);
        return nm;
    endfunction

    function automatic logic [CNT_W-1:0] inc_cnt(logic [CNT_W-1:0] n);
        return (n < CNT_W'(MAX_TEXT_CHARS)) ? n + 1'b1 : n;
    endfunction

    function automatic logic is_letter(logic [7:0] ch);
        return ch == "." || ch == "_" || (ch >= "a" && ch <= "z") ||
               (ch >= "A" && ch <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] ch);
        unique case (ch)
            "0":     return 8'h00;
            "e":     return CH_EOT;
            "(":     return "{";
            ")":     return "}";
            "t":     return 8'h09;
            "n":     return 8'h0A;
            default: return ch;
        endcase
    endfunction

    // scan step: next state and the tokens of this byte
    always_comb
    begin
        logic              do_idle;
        logic signed [9:0] kcode;
        logic signed [9:0] eqc;
        res_t              txt;

        mode_next = mode_reg;
        name_next = name_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        oct_next  = oct_reg;
        line_next = line_reg;
        esc_next  = esc_reg;
        nres      = '0;
        do_idle   = 1'b0;
        eqc       = '0;
        for (int i = 0; i < MAX_RES; i++)
            res[i] = mk_plain(TK_EOF, line_reg);

        kcode = TK_IDENT;
        for (int k = 0; k < NUM_KW; k++)
            if (name_reg == KW_NAME[k])
                kcode = TK_KW_BASE + 10'(k);

        txt.token_code  = kcode;
        txt.int_value   = '0;
        txt.name_text   = name_reg;
        txt.text_length = 7'(cnt_reg);
        txt.line_number = line_reg;
        txt.last        = 1'b0;

        if (eoi)
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    res[nres] = txt; nres = nres + 1'b1;
                end
                M_NUMBER:
                begin
                    txt.token_code = TK_INT; txt.int_value = acc_reg;
                    res[nres] = txt; nres = nres + 1'b1;
                end
                M_STRING:
                begin
                    txt.token_code = TK_STRING;
                    res[nres] = txt; nres = nres + 1'b1;
                end
                M_SLASH: begin res[nres] = mk_plain(ch_code("/"), line_reg); nres = nres + 1'b1; end
                M_LT:    begin res[nres] = mk_plain(ch_code("<"), line_reg); nres = nres + 1'b1; end
                M_GT:    begin res[nres] = mk_plain(ch_code(">"), line_reg); nres = nres + 1'b1; end
                M_BANG:  begin res[nres] = mk_plain(ch_code("!"), line_reg); nres = nres + 1'b1; end
                M_EQ:    begin res[nres] = mk_plain(ch_code("="), line_reg); nres = nres + 1'b1; end
                M_PLUS:  begin res[nres] = mk_plain(ch_code("+"), line_reg); nres = nres + 1'b1; end
                M_MINUS: begin res[nres] = mk_plain(ch_code("-"), line_reg); nres = nres + 1'b1; end
                M_EQLT:
                begin
                    res[0] = mk_plain(ch_code("="), line_reg);
                    res[1] = mk_plain(ch_code("<"), line_reg);
                    nres = 2'd2;
                end
                M_EQGT:
                begin
                    res[0] = mk_plain(ch_code("="), line_reg);
                    res[1] = mk_plain(ch_code(">"), line_reg);
                    nres = 2'd2;
                end
                default: ;
            endcase
            esc_next  = 1'b0;
            res[nres] = mk_plain(TK_EOF, line_reg);
            nres      = nres + 1'b1;
            mode_next = M_DONE;
        end
        else
        begin
            unique case (mode_reg)
                M_IDENT:
                    if (is_letter(c) || is_digit(c))
                    begin
                        name_next = put_char(name_reg, cnt_reg, c);
                        cnt_next  = inc_cnt(cnt_reg);
                    end
                    else
                    begin
                        res[0] = txt; nres = 2'd1; do_idle = 1'b1;
                    end
                M_NUMBER:
                    if (is_digit(c))
                    begin
                        acc_next  = 16'(acc_reg * (oct_reg ? 16'd8 : 16'd10)) +
                                    {12'd0, c[3:0]};
                        name_next = put_char(name_reg, cnt_reg, c);
                        cnt_next  = inc_cnt(cnt_reg);
                    end
                    else
                    begin
                        txt.token_code = TK_INT; txt.int_value = acc_reg;
                        res[0] = txt; nres = 2'd1; do_idle = 1'b1;
                    end
                M_SLASH:
                    if (c == "*")
                        mode_next = M_COMMENT;
                    else
                    begin
                        res[0] = mk_plain(ch_code("/"), line_reg); nres = 2'd1; do_idle = 1'b1;
                    end
                M_COMMENT:
                    if (c == "*")
                        mode_next = M_CSTAR;
                M_CSTAR:
                    if (c == "/")
                        mode_next = M_IDLE;
                    else if (c != "*")
                        mode_next = M_COMMENT;
                M_STRING:
                    priority if (esc_reg)
                    begin
                        name_next = put_char(name_reg, cnt_reg, unescape(c));
                        cnt_next  = inc_cnt(cnt_reg);
                        esc_next  = 1'b0;
                    end
                    else if (c == "\"")
                    begin
                        txt.token_code = TK_STRING;
                        res[0] = txt; nres = 2'd1; mode_next = M_IDLE;
                    end
                    else if (c == "*")
                        esc_next = 1'b1;
                    else
                    begin
                        name_next = put_char(name_reg, cnt_reg, c);
                        cnt_next  = inc_cnt(cnt_reg);
                    end
                M_LT, M_GT:
                begin
                    if (c == "=")
                    begin
                        res[0] = mk_plain(mode_reg == M_LT ? TK_LE : TK_GE, line_reg);
                        nres = 2'd1; mode_next = M_IDLE;
                    end
                    else if (c == (mode_reg == M_LT ? "<" : ">"))
                    begin
                        res[0] = mk_plain(mode_reg == M_LT ? TK_SHL : TK_SHR, line_reg);
                        nres = 2'd1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        res[0] = mk_plain(ch_code(mode_reg == M_LT ? "<" : ">"), line_reg);
                        nres = 2'd1; do_idle = 1'b1;
                    end
                end
                M_BANG, M_PLUS, M_MINUS:
                begin
                    logic [7:0]        first;
                    logic [7:0]        match;
                    logic signed [9:0] pcode;
                    unique case (mode_reg)
                        M_BANG:  begin first = "!"; match = "="; pcode = TK_NE;  end
                        M_PLUS:  begin first = "+"; match = "+"; pcode = TK_INC; end
                        default: begin first = "-"; match = "-"; pcode = TK_DEC; end
                    endcase
                    if (c == match)
                    begin
                        res[0] = mk_plain(pcode, line_reg); nres = 2'd1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        res[0] = mk_plain(ch_code(first), line_reg); nres = 2'd1; do_idle = 1'b1;
                    end
                end
                M_EQ:
                begin
                    unique case (c)
                        "=":     eqc = TK_EQEQ;
                        "+":     eqc = TK_EQPLUS;
                        "-":     eqc = TK_EQMINUS;
                        "*":     eqc = TK_EQMUL;
                        "/":     eqc = TK_EQDIV;
                        "%":     eqc = TK_EQMOD;
                        "&":     eqc = TK_EQAND;
                        "|":     eqc = TK_EQOR;
                        default: eqc = '0;
                    endcase
                    priority if (c == "<")
                        mode_next = M_EQLT;
                    else if (c == ">")
                        mode_next = M_EQGT;
                    else if (eqc != '0)
                    begin
                        res[0] = mk_plain(eqc, line_reg); nres = 2'd1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        res[0] = mk_plain(ch_code("="), line_reg); nres = 2'd1; do_idle = 1'b1;
                    end
                end
                M_EQLT, M_EQGT:
                begin
                    logic [7:0] sign;
                    sign = (mode_reg == M_EQLT) ? "<" : ">";
                    priority if (c == sign)
                    begin
                        res[0] = mk_plain(mode_reg == M_EQLT ? TK_EQSHL : TK_EQSHR, line_reg);
                        nres = 2'd1; mode_next = M_IDLE;
                    end
                    else if (c == "=")
                    begin
                        res[0] = mk_plain(ch_code("="), line_reg);
                        res[1] = mk_plain(mode_reg == M_EQLT ? TK_LE : TK_GE, line_reg);
                        nres = 2'd2; mode_next = M_IDLE;
                    end
                    else
                    begin
                        res[0] = mk_plain(ch_code("="), line_reg);
                        res[1] = mk_plain(ch_code(sign), line_reg);
                        nres = 2'd2; do_idle = 1'b1;
                    end
                end
                M_DONE:
                begin
                    res[0] = mk_plain(TK_EOF, line_reg); nres = 2'd1;
                end
                default: do_idle = 1'b1;
            endcase

            // rescan the byte from idle
            if (do_idle)
            begin
                mode_next = M_IDLE;
                priority if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D)
                    ;
                else if (c == CH_EOT)
                begin
                    res[nres] = mk_plain(TK_EOF, line_reg); nres = nres + 1'b1;
                    mode_next = M_DONE;
                end
                else if (is_letter(c) || is_digit(c))
                begin
                    name_next = put_char(SPACES, '0, c);
                    cnt_next  = CNT_W'(1);
                    acc_next  = is_digit(c) ? {12'd0, c[3:0]} : 16'd0;
                    oct_next  = (c == "0");
                    esc_next  = 1'b0;
                    mode_next = is_digit(c) ? M_NUMBER : M_IDENT;
                end
                else if (c == "\"")
                begin
                    name_next = SPACES;
                    cnt_next  = '0;
                    acc_next  = '0;
                    oct_next  = 1'b0;
                    esc_next  = 1'b0;
                    mode_next = M_STRING;
                end
                else if (c == "/") mode_next = M_SLASH;
                else if (c == "<") mode_next = M_LT;
                else if (c == ">") mode_next = M_GT;
                else if (c == "!") mode_next = M_BANG;
                else if (c == "=") mode_next = M_EQ;
                else if (c == "+") mode_next = M_PLUS;
                else if (c == "-") mode_next = M_MINUS;
                else
                begin
                    res[nres] = mk_plain(ch_code(c), line_reg); nres = nres + 1'b1;
                end
            end

            if (c == 8'h0A)
                line_next = line_reg + 16'd1;
        end

        if (nres != '0)
            res[nres - 1'b1].last = 1'b1;
    end

    assign drain        = out_chan.valid && out_chan.ready;
    assign in_chan.ready = (qcnt_reg == '0) || (qcnt_reg == 2'd1 && out_chan.ready);
    assign accept       = in_chan.valid && in_chan.ready;

    always_comb
    begin
        qcnt_next = qcnt_reg;
        rdp_next  = rdp_reg;
        if (drain)
        begin
            qcnt_next = qcnt_reg - 1'b1;
            rdp_next  = rdp_reg + 1'b1;
        end
        if (accept)
        begin
            qcnt_next = nres;
            rdp_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            name_reg <= SPACES;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            oct_reg  <= 1'b0;
            line_reg <= 16'd1;
            esc_reg  <= 1'b0;
            qcnt_reg <= '0;
            rdp_reg  <= '0;
        end
        else
        begin
            qcnt_reg <= qcnt_next;
            rdp_reg  <= rdp_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                name_reg <= name_next;
                cnt_reg  <= cnt_next;
                acc_reg  <= acc_next;
                oct_reg  <= oct_next;
                line_reg <= line_next;
                esc_reg  <= esc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            for (int i = 0; i < MAX_RES; i++)
                buf_reg[i] <= res[i];
    end

    assign out_chan.valid       = (qcnt_reg != '0);
    assign out_chan.token_code  = buf_reg[rdp_reg].token_code;
    assign out_chan.int_value   = buf_reg[rdp_reg].int_value;
    assign out_chan.name_text   = buf_reg[rdp_reg].name_text;
    assign out_chan.text_length = buf_reg[rdp_reg].text_length;
    assign out_chan.line_number = buf_reg[rdp_reg].line_number;
    assign out_chan.last        = buf_reg[rdp_reg].last;

    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (qcnt_reg == '0 || (qcnt_reg == 2'd1 && drain)))
        else $error("byte taken while tokens still pending");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_DONE |=> mode_reg == M_DONE)
        else $error("scanner left end of file state");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (drain && out_chan.last && !accept) |=> !out_chan.valid)
        else $error("tokens left after last of a byte");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg + rdp_reg <= 2'(MAX_RES))
        else $error("result buffer pointer past end");

endmodule

[sim/b_language_token_scanner_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b_language_token_scanner_checker
// Watches the byte and token channels, predicts the token stream of every
// accepted request and compares each token field by field, in order.
// ----------------------------------------------------------------------------
module b_language_token_scanner_checker
    import bts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bts_in_if      in_chan,
    bts_out_if     out_chan,
    output int     fail_count,
    output int     pending_tokens,
    output int     tokens_seen
);

    mode_t       mode;
    logic [63:0] name_buf;
    logic [6:0]  char_cnt;
    logic [15:0] num_acc;
    logic        octal;
    logic [15:0] line_cnt;
    logic        esc;

    res_t token_q[$];
    res_t new_toks[$];

    function automatic logic is_letter(logic [7:0] c);
        return c == "." || c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic push_tok(logic signed [9:0] code, logic [15:0] ival,
                            logic [63:0] name, logic [6:0] len);
        res_t t;
        if (new_toks.size() >= MAX_RES)
            return;
        t.token_code  = code;
        t.int_value   = ival;
        t.name_text   = name;
        t.text_length = len;
        t.line_number = line_cnt;
        t.last        = 1'b0;
        new_toks.push_back(t);
    endtask

    task automatic push_plain(logic signed [9:0] code);
        push_tok(code, 16'd0, SPACES, 7'd0);
    endtask

    task automatic push_char(logic [7:0] ch);
        push_plain(10'(ch));
    endtask

    task automatic push_text(logic signed [9:0] code);
        push_tok(code, code == TK_INT ? num_acc : 16'd0, name_buf, char_cnt);
    endtask

    task automatic push_ident();
        logic signed [9:0] code;
        code = TK_IDENT;
        for (int k = 0; k < NUM_KW; k++)
            if (name_buf == KW_NAME[k])
                code = TK_KW_BASE + 10'(k);
        push_text(code);
    endtask

    task automatic clear_token();
        name_buf = SPACES;
        char_cnt = '0;
        num_acc  = '0;
        octal    = 1'b0;
        esc      = 1'b0;
    endtask

    task automatic store_char(logic [7:0] c);
        if (char_cnt < NAME_CHARS)
            name_buf[63 - 8 * char_cnt -: 8] = c;
        if (char_cnt < MAX_TEXT_CHARS)
            char_cnt++;
    endtask

    task automatic scan_idle(logic [7:0] c);
        mode = M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d)
            return;
        if (c == CH_EOT)
        begin
            push_plain(TK_EOF);
            mode = M_DONE;
        end
        else if (is_letter(c))
        begin
            clear_token();
            store_char(c);
            mode = M_IDENT;
        end
        else if (is_digit(c))
        begin
            clear_token();
            octal   = (c == "0");
            num_acc = 16'(c - "0");
            store_char(c);
            mode = M_NUMBER;
        end
        else
        begin
            case (c)
                "/": mode = M_SLASH;
                "\"":
                begin
                    clear_token();
                    mode = M_STRING;
                end
                "<": mode = M_LT;
                ">": mode = M_GT;
                "!": mode = M_BANG;
                "=": mode = M_EQ;
                "+": mode = M_PLUS;
                "-": mode = M_MINUS;
                default: push_char(c);
            endcase
        end
    endtask

    task automatic pair(logic [7:0] c, logic [7:0] match, logic signed [9:0] code,
                        logic [7:0] first);
        if (c == match)
        begin
            push_plain(code);
            mode = M_IDLE;
        end
        else
        begin
            push_char(first);
            scan_idle(c);
        end
    endtask

    function automatic logic [7:0] unescape(logic [7:0] c);
        case (c)
            "0":     return 8'h00;
            "e":     return CH_EOT;
            "(":     return "{";
            ")":     return "}";
            "t":     return 8'h09;
            "n":     return 8'h0a;
            default: return c;
        endcase
    endfunction

    task automatic eq_shift(logic [7:0] c, logic [7:0] sign, logic signed [9:0] shcode,
                            logic signed [9:0] eqcode);
        if (c == sign)
        begin
            push_plain(shcode);
            mode = M_IDLE;
            return;
        end
        push_char("=");
        if (c == "=")
        begin
            push_plain(eqcode);
            mode = M_IDLE;
            return;
        end
        push_char(sign);
        scan_idle(c);
    endtask

    task automatic scan_byte(logic [7:0] c);
        logic signed [9:0] code;
        case (mode)
            M_IDENT:
                if (is_letter(c) || is_digit(c))
                    store_char(c);
                else
                begin
                    push_ident();
                    scan_idle(c);
                end
            M_NUMBER:
                if (is_digit(c))
                begin
                    num_acc = 16'(num_acc * (octal ? 16'd8 : 16'd10) + 16'(c - "0"));
                    store_char(c);
                end
                else
                begin
                    push_text(TK_INT);
                    scan_idle(c);
                end
            M_SLASH:
                if (c == "*")
                    mode = M_COMMENT;
                else
                begin
                    push_char("/");
                    scan_idle(c);
                end
            M_COMMENT:
                if (c == "*")
                    mode = M_CSTAR;
            M_CSTAR:
                if (c == "/")
                    mode = M_IDLE;
                else if (c != "*")
                    mode = M_COMMENT;
            M_STRING:
                if (esc)
                begin
                    store_char(unescape(c));
                    esc = 1'b0;
                end
                else if (c == "\"")
                begin
                    push_text(TK_STRING);
                    mode = M_IDLE;
                end
                else if (c == "*")
                    esc = 1'b1;
                else
                    store_char(c);
            M_LT:
                if (c == "=")
                begin
                    push_plain(TK_LE);
                    mode = M_IDLE;
                end
                else
                    pair(c, "<", TK_SHL, "<");
            M_GT:
                if (c == "=")
                begin
                    push_plain(TK_GE);
                    mode = M_IDLE;
                end
                else
                    pair(c, ">", TK_SHR, ">");
            M_BANG:  pair(c, "=", TK_NE, "!");
            M_PLUS:  pair(c, "+", TK_INC, "+");
            M_MINUS: pair(c, "-", TK_DEC, "-");
            M_EQ:
            begin
                code = '0;
                case (c)
                    "=": code = TK_EQEQ;
                    "+": code = TK_EQPLUS;
                    "-": code = TK_EQMINUS;
                    "*": code = TK_EQMUL;
                    "/": code = TK_EQDIV;
                    "%": code = TK_EQMOD;
                    "&": code = TK_EQAND;
                    "|": code = TK_EQOR;
                    default: ;
                endcase
                if (c == "<")
                    mode = M_EQLT;
                else if (c == ">")
                    mode = M_EQGT;
                else if (code != 0)
                begin
                    push_plain(code);
                    mode = M_IDLE;
                end
                else
                begin
                    push_char("=");
                    scan_idle(c);
                end
            end
            M_EQLT: eq_shift(c, "<", TK_EQSHL, TK_LE);
            M_EQGT: eq_shift(c, ">", TK_EQSHR, TK_GE);
            M_DONE: push_plain(TK_EOF);
            default: scan_idle(c);
        endcase
    endtask

    // flush whatever token is open, then close the source
    task automatic scan_end();
        case (mode)
            M_IDENT:  push_ident();
            M_NUMBER: push_text(TK_INT);
            M_STRING: push_text(TK_STRING);
            M_SLASH:  push_char("/");
            M_LT:     push_char("<");
            M_GT:     push_char(">");
            M_BANG:   push_char("!");
            M_EQ:     push_char("=");
            M_EQLT:
            begin
                push_char("=");
                push_char("<");
            end
            M_EQGT:
            begin
                push_char("=");
                push_char(">");
            end
            M_PLUS:   push_char("+");
            M_MINUS:  push_char("-");
            default: ;
        endcase
        esc = 1'b0;
        push_plain(TK_EOF);
        mode = M_DONE;
    endtask

    task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            mode        = M_IDLE;
            clear_token();
            line_cnt    = 16'd1;
            fail_count  = 0;
            tokens_seen = 0;
            token_q.delete();
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                tokens_seen++;
                if (token_q.size() == 0)
                begin
                    $error("unexpected token %0d", out_chan.token_code);
                    fail_count++;
                end
                else
                begin
                    e = token_q.pop_front();
                    check_field("token_code", 64'(e.token_code), 64'(out_chan.token_code));
                    check_field("int_value", e.int_value, out_chan.int_value);
                    check_field("name_text", e.name_text, out_chan.name_text);
                    check_field("text_length", e.text_length, out_chan.text_length);
                    check_field("line_number", e.line_number, out_chan.line_number);
                    check_field("last", e.last, out_chan.last);
                end
            end
            if (in_chan.valid && in_chan.ready)
            begin
                new_toks.delete();
                if (in_chan.end_of_input)
                    scan_end();
                else
                begin
                    scan_byte(in_chan.input_byte);
                    if (in_chan.input_byte == 8'h0a)
                        line_cnt++;
                end
                if (new_toks.size() > 0)
                    new_toks[new_toks.size() - 1].last = 1'b1;
                foreach (new_toks[i])
                    token_q.push_back(new_toks[i]);
            end
        end
        pending_tokens = token_q.size();
    end

endmodule

[sim/b_language_token_scanner_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b_language_token_scanner_test
// Feeds directed and random B source fragments to the token scanner with
// bursty sending and random output stalls; the checker predicts each token.
// ----------------------------------------------------------------------------
module b_language_token_scanner_test
    import bts_pkg::*;
;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_tokens;
    int   tokens_seen;
    int   bytes_sent;
    int   gap_left;
    int   stall_mode = 0;

    bts_in_if  in_chan();
    bts_out_if out_chan();

    b_language_token_scanner uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    b_language_token_scanner_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_chan        (in_chan),
        .out_chan       (out_chan),
        .fail_count     (fail_count),
        .pending_tokens (pending_tokens),
        .tokens_seen    (tokens_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // receiver: phases of no stall, light and heavy stall
    always @(posedge clk)
    begin
        if ($urandom_range(0, 39) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       out_chan.ready <= 1'b1;
            1:       out_chan.ready <= ($urandom_range(0, 3) != 0);
            default: out_chan.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // one request; gaps come between bursts
    task automatic send(logic [7:0] b, logic eoi);
        if (gap_left == 0 && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(0, 4) == 0 ? $urandom_range(5, 12) : $urandom_range(1, 3);
        while (gap_left > 0)
        begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        in_chan.valid        <= 1'b1;
        in_chan.input_byte   <= b;
        in_chan.end_of_input <= eoi;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens != 0)
            @(posedge clk);
    endtask

    // restart the scanner's source: close it, then clear via end of file
    // is impossible, so random streams stay open until the final end

    function automatic string pick_piece();
        string pieces[$] = '{"auto ", "while(", "x1_a.b ", "0777 ", "1234567 ",
            "\"ab*n*e*(\" ", "/* c*/ ", "<= ", "<<", ">=", ">>", "!=", "==",
            "=+", "=-", "=*", "=/", "=%", "=<<", "=>>", "=&", "=|", "++", "--",
            "=< ", "=> ", "=^", "/x", "=<=", "=>=", "extrn ", "goto ", "return ",
            "\n", "\t", "; ", "{}", "\"*\"q\"", "verylongidentifier ", "089 "};
        return pieces[$urandom_range(0, pieces.size() - 1)];
    endfunction

    initial
    begin
        string rnd;
        in_chan.valid        <= 1'b0;
        in_chan.input_byte   <= 8'h00;
        in_chan.end_of_input <= 1'b0;
        gap_left   = 0;
        bytes_sent = 0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: keywords, numbers, strings, operators, odd cases
        send_text("case default else if switch 0 65535 08 99999\n");
        send_text("\"**\"\"*'*t*0*)\" /**/ =<<=>>=<a/");
        wait_drained();
        send(8'hff, 1'b0);
        send(8'h80, 1'b0);

        // random fragments, with some noise bytes
        while (bytes_sent < 215)
        begin
            if ($urandom_range(0, 5) == 0)
                send(8'($urandom_range(0, 255)) & ~8'h04 | 8'h01, 1'b0);
            else
            begin
                rnd = pick_piece();
                send_text(rnd);
            end
            if ($urandom_range(0, 60) == 0)
                wait_drained();
        end
        send(8'h00, 1'b1);
        send(8'h41, 1'b0);
        send(CH_EOT, 1'b0);
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d source bytes, checked %0d tokens", bytes_sent, tokens_seen);
        $display("covering keywords, numbers, strings, comments and operators.");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/bts_pkg.sv
hdl/bts_in_if.sv
hdl/bts_out_if.sv
hdl/b_language_token_scanner.sv
sim/b_language_token_scanner_checker.sv
sim/b_language_token_scanner_test.sv
